[design/vms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibration magnitude statistics package
// Shared widths, the controller command bundle and the result record.
// ----------------------------------------------------------------------------
package vms_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int COUNT_BITS  = 32;
  localparam int WORD_BITS   = 24;
  localparam int AXES        = 3;

  localparam int SQ_BITS         = 2 * SAMPLE_BITS;
  localparam int REM_BITS        = SAMPLE_BITS + 2;
  localparam int SUM_BITS        = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS       = $clog2(SUM_BITS);
  localparam int IN_DATA_BITS    = ((AXES * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_BITS = 7 * SAMPLE_BITS + COUNT_BITS;
  localparam int OUT_DATA_BITS   = ((OUT_FIELDS_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic load;       // take a new beat from the input side
    logic clear;      // the beat is a clear command
    logic sq_step;    // square one axis and accumulate
    logic root_step;  // one result bit of the square root
    logic update;     // fold the magnitude into the statistics
    logic div_step;   // one quotient bit of the mean
    logic out_load;   // capture the result into the output register
  } vms_cmd_t;

  // Packed with the first output field in the lowest bits.
  typedef struct packed {
    logic        [COUNT_BITS-1:0]  sample_count;
    logic        [SAMPLE_BITS-1:0] mean_magnitude;
    logic        [SAMPLE_BITS-1:0] max_magnitude;
    logic        [SAMPLE_BITS-1:0] min_magnitude;
    logic        [SAMPLE_BITS-1:0] magnitude;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_x;
  } vms_result_t;

endpackage

[design/vms_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibration magnitude statistics controller
// Sequences square, root, update and divide phases and owns both handshakes.
// ----------------------------------------------------------------------------
module vms_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             s_tuser_i,
  output logic             s_tready_o,
  input  logic             m_tready_i,
  output logic             m_tvalid_o,
  output vms_pkg::vms_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e                         state_q, state_d;
  logic [vms_pkg::STEP_BITS-1:0]  step_q, step_d;
  logic                           m_valid_q, m_valid_d;
  logic                           accept;
  logic                           out_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign accept     = s_tvalid_i & s_tready_o;
  assign out_free   = ~m_valid_q | m_tready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.clear     = s_tuser_i;
    cmd_o.sq_step   = (state_q == ST_SQUARE);
    cmd_o.root_step = (state_q == ST_ROOT);
    cmd_o.update    = (state_q == ST_UPDATE);
    cmd_o.div_step  = (state_q == ST_DIVIDE);
    cmd_o.out_load  = (state_q == ST_FINISH) & out_free;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q + 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (accept) begin
          state_d = s_tuser_i ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (step_q == vms_pkg::STEP_BITS'(vms_pkg::AXES - 1)) begin
          state_d = ST_ROOT;
          step_d  = '0;
        end
      end
      ST_ROOT: begin
        if (step_q == vms_pkg::STEP_BITS'(vms_pkg::SAMPLE_BITS - 1)) begin
          state_d = ST_UPDATE;
          step_d  = '0;
        end
      end
      ST_UPDATE: begin
        state_d = ST_DIVIDE;
        step_d  = '0;
      end
      ST_DIVIDE: begin
        if (step_q == vms_pkg::STEP_BITS'(vms_pkg::SUM_BITS - 1)) begin
          state_d = ST_FINISH;
          step_d  = '0;
        end
      end
      ST_FINISH: begin
        step_d = '0;
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // A new result may replace the old one in the cycle the old one is taken.
  always_comb begin
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

[design/vms_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibration magnitude statistics datapath
// Shared squarer, bit-serial square root, statistics and restoring divider.
// ----------------------------------------------------------------------------
module vms_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vms_pkg::vms_cmd_t              cmd_i,
  input  logic [vms_pkg::WORD_BITS-1:0]  x_data_i,
  input  logic [vms_pkg::WORD_BITS-1:0]  y_data_i,
  input  logic [vms_pkg::WORD_BITS-1:0]  z_data_i,
  output vms_pkg::vms_result_t           result_o
);

  localparam int S = vms_pkg::SAMPLE_BITS;
  localparam int C = vms_pkg::COUNT_BITS;
  localparam int W = vms_pkg::WORD_BITS;

  logic [S-1:0] x_smp, y_smp, z_smp;

  logic [S-1:0]                    ax_q, ay_q, az_q;
  logic [vms_pkg::AXES*S-1:0]      sqop_q;
  logic [vms_pkg::SQ_BITS-1:0]     ssq_q;
  logic [vms_pkg::REM_BITS-1:0]    rem_q;
  logic [S-1:0]                    root_q;
  logic [vms_pkg::SUM_BITS-1:0]    dv_q;
  logic [C-1:0]                    dr_q;
  vms_pkg::vms_result_t            res_q;

  logic [S-1:0]                    min_q, max_q;
  logic [vms_pkg::SUM_BITS-1:0]    sum_q;
  logic [C-1:0]                    cnt_q;

  logic [S-1:0]                    sq_in, sq_abs;
  logic [vms_pkg::SQ_BITS-1:0]     sq_prod;
  logic [vms_pkg::REM_BITS-1:0]    rem_sh, trial, rem_next;
  logic                            root_ge;
  logic                            cnt_sat;
  logic [vms_pkg::SUM_BITS-1:0]    sum_upd;
  logic [C:0]                      dr_sh, dr_diff;
  logic                            dr_ge;
  logic [C-1:0]                    dr_next;
  logic [S-1:0]                    mean;

  assign x_smp = x_data_i[W-1 -: S];
  assign y_smp = y_data_i[W-1 -: S];
  assign z_smp = z_data_i[W-1 -: S];

  // The most negative sample maps to 2^(S-1), which still fits unsigned.
  assign sq_in   = sqop_q[S-1:0];
  assign sq_abs  = sq_in[S-1] ? (~sq_in + 1'b1) : sq_in;
  assign sq_prod = vms_pkg::SQ_BITS'(sq_abs) * vms_pkg::SQ_BITS'(sq_abs);

  // Two operand bits enter the partial remainder per step.
  assign rem_sh   = {rem_q[S-1:0], ssq_q[vms_pkg::SQ_BITS-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign root_ge  = (rem_sh >= trial);
  assign rem_next = root_ge ? (rem_sh - trial) : rem_sh;

  assign cnt_sat = &cnt_q;
  assign sum_upd = cnt_sat ? sum_q : (sum_q + vms_pkg::SUM_BITS'(root_q));

  assign dr_sh   = {dr_q, dv_q[vms_pkg::SUM_BITS-1]};
  assign dr_ge   = (dr_sh >= {1'b0, cnt_q});
  assign dr_diff = dr_sh - {1'b0, cnt_q};
  assign dr_next = dr_ge ? dr_diff[C-1:0] : dr_sh[C-1:0];

  assign mean = (cnt_q == '0) ? '0 : dv_q[S-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= cmd_i.clear ? '0 : x_smp;
      ay_q   <= cmd_i.clear ? '0 : y_smp;
      az_q   <= cmd_i.clear ? '0 : z_smp;
      sqop_q <= {z_smp, y_smp, x_smp};
      ssq_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sq_step) begin
      ssq_q  <= ssq_q + sq_prod;
      sqop_q <= sqop_q >> S;
    end
    if (cmd_i.root_step) begin
      ssq_q  <= ssq_q << 2;
      rem_q  <= rem_next;
      root_q <= {root_q[S-2:0], root_ge};
    end
    if (cmd_i.update) begin
      dv_q <= sum_upd;
      dr_q <= '0;
    end
    if (cmd_i.div_step) begin
      dv_q <= {dv_q[vms_pkg::SUM_BITS-2:0], dr_ge};
      dr_q <= dr_next;
    end
    if (cmd_i.out_load) begin
      res_q.accel_x        <= ax_q;
      res_q.accel_y        <= ay_q;
      res_q.accel_z        <= az_q;
      res_q.magnitude      <= root_q;
      res_q.min_magnitude  <= min_q;
      res_q.max_magnitude  <= max_q;
      res_q.mean_magnitude <= mean;
      res_q.sample_count   <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '1;
      max_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.load && cmd_i.clear) begin
      min_q <= '1;
      max_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.update) begin
      if (root_q < min_q) begin
        min_q <= root_q;
      end
      if (root_q > max_q) begin
        max_q <= root_q;
      end
      sum_q <= sum_upd;
      if (!cnt_sat) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign result_o = res_q;

endmodule

[design/vibration_magnitude_stats.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibration magnitude statistics
// A sample beat is squared one axis per step on one shared multiplier,
// then runs 20 square root steps, one update step and 52 restoring
// divide steps, and its result is loaded from the finish state into the
// output register. A clear beat goes straight to the finish state.
// The next beat is taken in the cycle the result appears, not before,
// and the finish state waits while the output register is still full.
// Reset clears min to all ones and max, sum and count to zero.
// ----------------------------------------------------------------------------
module vibration_magnitude_stats (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_data, y_data, z_data
  input  logic [vms_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // cmd
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // accel_x, accel_y, accel_z, magnitude, min_magnitude, max_magnitude,
  // mean_magnitude, sample_count, zero padding
  output logic [vms_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

  localparam int W = vms_pkg::WORD_BITS;

  vms_pkg::vms_cmd_t    cmd;
  vms_pkg::vms_result_t result;

  vms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  vms_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .x_data_i (s_axis_tdata[W-1:0]),
    .y_data_i (s_axis_tdata[2*W-1:W]),
    .z_data_i (s_axis_tdata[3*W-1:2*W]),
    .result_o (result)
  );

  assign m_axis_tdata = vms_pkg::OUT_DATA_BITS'(result);

endmodule
